### design/assert_macros.svh
// Assertion macros used by the checker module.
// Needs nothing else; each macro expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define GHI_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset cycles included.
`define GHI_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/ghi_pkg.sv
// Shared types, constants and helpers for the gyro heading integrator.
// No dependencies; imported by every module of the block.
package ghi_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_CALIB_READINGS = 2'd0;
  localparam logic [1:0] REG_INTERVAL_MS    = 2'd1;
  localparam logic [1:0] REG_GAIN           = 2'd2;
  localparam logic [1:0] REG_TOLERANCE_DEG  = 2'd3;

  // Shared multiply/divide unit geometry
  localparam int MD_A_W   = 41;  // multiplicand / dividend low part / quotient
  localparam int MD_B_W   = 32;  // multiplier
  localparam int MD_D_W   = 16;  // divisor and remainder
  localparam int MD_P_W   = 73;  // product
  localparam int MD_CNT_W = 6;

  localparam logic OP_MUL = 1'b0;
  localparam logic OP_DIV = 1'b1;

  typedef struct packed {
    logic start;
    logic op;
  } md_ctl_t;

  // Heading arithmetic, Q16.16 degrees
  localparam logic [24:0] DEG360_Q    = 25'd23592960;
  localparam logic [24:0] INC_LIMIT_Q = 25'd23527424;
  // Largest dt*q that does not saturate the increment
  localparam logic [40:0] INC_TOP     = {INC_LIMIT_Q, 16'h0000}
                                        | 41'h0FFFF;
  // Any quotient at or above this saturates for every dt of one or more
  localparam logic [40:0] Q_SAT       = INC_TOP + 41'd1;

  localparam logic [10:0] CALIB_RESET   = 11'd64;
  localparam logic [15:0] INTERVAL_RESET = 16'd10;
  localparam logic [31:0] GAIN_RESET    = 32'd37581;
  localparam logic [7:0]  TOL_RESET     = 8'd10;

  // Effective calibration count: zero reads as one, above 1024 as 1024
  function automatic logic [10:0] eff_calib(input logic [10:0] n);
    logic [10:0] r;
    if (n == 11'd0) r = 11'd1;
    else if (n > 11'd1024) r = 11'd1024;
    else r = n;
    return r;
  endfunction

endpackage

### design/ghi_muldiv.sv
// Shared iterative unit: shift-add multiply and restoring divide.
// Depends on ghi_pkg; one product or quotient bit per cycle, one shared register.
module ghi_muldiv import ghi_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  md_ctl_t           ctl,
  input  logic [MD_A_W-1:0] opa,      // multiplicand, or dividend low bits
  input  logic [MD_B_W-1:0] opb,      // multiplier
  input  logic [MD_D_W-1:0] rem0,     // dividend high bits, below divisor
  input  logic [MD_D_W-1:0] divisor,
  output logic              done,
  output logic [MD_P_W-1:0] result    // product, or quotient in low bits
);

  logic                busy_r, busy_nxt;
  logic                op_r, op_nxt;
  logic                done_r, done_nxt;
  logic [MD_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [MD_A_W-1:0]   a_r, a_nxt;
  logic [MD_D_W-1:0]   dvs_r, dvs_nxt;
  logic [MD_P_W-1:0]   prod_r, prod_nxt;

  logic [MD_A_W:0]     mul_sum;
  logic [MD_D_W:0]     shifted;
  logic [MD_D_W:0]     diff;
  logic                ge;
  logic [MD_D_W-1:0]   rem_new;
  logic [MD_P_W-1:0]   step_val;

  always_comb begin
    mul_sum  = {1'b0, prod_r[MD_P_W-1:MD_B_W]}
               + (prod_r[0] ? {1'b0, a_r} : '0);
    shifted  = {prod_r[MD_A_W+MD_D_W-1:MD_A_W], prod_r[MD_A_W-1]};
    diff     = shifted - {1'b0, dvs_r};
    ge       = (shifted >= {1'b0, dvs_r});
    rem_new  = ge ? diff[MD_D_W-1:0] : shifted[MD_D_W-1:0];
    if (op_r == OP_MUL) begin
      step_val = {mul_sum, prod_r[MD_B_W-1:1]};
    end else begin
      step_val = {{(MD_P_W-MD_A_W-MD_D_W){1'b0}}, rem_new,
                  prod_r[MD_A_W-2:0], ge};
    end

    busy_nxt = busy_r;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    dvs_nxt  = dvs_r;
    prod_nxt = prod_r;
    done_nxt = 1'b0;

    if (ctl.start) begin
      busy_nxt = 1'b1;
      op_nxt   = ctl.op;
      a_nxt    = opa;
      dvs_nxt  = divisor;
      if (ctl.op == OP_MUL) begin
        prod_nxt = MD_P_W'(opb);
        cnt_nxt  = MD_CNT_W'(MD_B_W - 1);
      end else begin
        prod_nxt = {{(MD_P_W-MD_A_W-MD_D_W){1'b0}}, rem0, opa};
        cnt_nxt  = MD_CNT_W'(MD_A_W - 1);
      end
    end else if (busy_r) begin
      prod_nxt = step_val;
      cnt_nxt  = cnt_r - MD_CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    op_r   <= op_nxt;
    a_r    <= a_nxt;
    dvs_r  <= dvs_nxt;
    prod_r <= prod_nxt;
  end

  assign done   = done_r;
  assign result = prod_r;

endmodule

### design/gyro_heading_integrator.sv
// Gyro heading integrator: bias calibration, run averaging, Q16.16 heading.
// Ordinary sample: accepted in S_IDLE, passed via S_DONE to the output register.
// Calibration end: bias divide (41-step divide). Heading update: multiply, divide,
// multiply (32-step multiply, 41-step divide, 32-step multiply), the divide skipped
// when the quotient would saturate; a stalled output holds the block. Synchronous rst_n low loads
// register defaults and restarts calibration. Depends on ghi_pkg, ghi_muldiv.
module gyro_heading_integrator import ghi_pkg::*; #(
  parameter int SAMPLE_BITS   = 16,
  parameter int MAX_RUN_COUNT = 65535
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input transactions
  input  logic        in_tvalid,
  output logic        in_tready,
  // from bit 0: rate_z (SAMPLE_BITS, signed), time_ms (32), zero fill to bytes
  input  logic [((SAMPLE_BITS+32+7)/8)*8-1:0] in_tdata,
  // Result transactions
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // from bit 0: heading_q (25), zero fill
  output logic [1:0]  out_tuser,   // from bit 0: facing_forward, calibrating
  // Configuration writes
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int CA_W = SAMPLE_BITS + 11;   // calibration accumulator
  localparam int CR_W = SAMPLE_BITS + 1;    // bias-corrected sample
  localparam int RS_W = SAMPLE_BITS + 17;   // run sum

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CDIV  = 3'd1;  // bias divide
  localparam logic [2:0] S_MUL1  = 3'd2;  // |sum| * gain
  localparam logic [2:0] S_DIV   = 3'd3;  // / run count
  localparam logic [2:0] S_MUL2  = 3'd4;  // * dt
  localparam logic [2:0] S_APPLY = 3'd5;  // add, wrap
  localparam logic [2:0] S_DONE  = 3'd6;  // hand result to the output register

  // Configuration registers
  logic [10:0] calib_cfg_r, calib_cfg_nxt;
  logic [15:0] interval_r, interval_nxt;
  logic [31:0] gain_r, gain_nxt;
  logic [7:0]  tol_r, tol_nxt;

  // Integrator state
  logic [2:0]                    state_r, state_nxt;
  logic [10:0]                   calib_left_r, calib_left_nxt;
  logic signed [CA_W-1:0]        calib_acc_r, calib_acc_nxt;
  logic signed [SAMPLE_BITS-1:0] bias_r, bias_nxt;
  logic signed [RS_W-1:0]        run_sum_r, run_sum_nxt;
  logic [15:0]                   run_count_r, run_count_nxt;
  logic [31:0]                   last_time_r, last_time_nxt;
  logic [24:0]                   heading_r, heading_nxt;

  // Working registers of one update
  logic                neg_r, neg_nxt;
  logic [31:0]         dt_r, dt_nxt;
  logic [15:0]         n_r, n_nxt;
  logic [24:0]         inc_r, inc_nxt;

  // Shared unit request
  md_ctl_t             md_ctl_r, md_ctl_nxt;
  logic [MD_A_W-1:0]   md_a_r, md_a_nxt;
  logic [MD_B_W-1:0]   md_b_r, md_b_nxt;
  logic [MD_D_W-1:0]   md_rem_r, md_rem_nxt;
  logic [MD_D_W-1:0]   md_dvs_r, md_dvs_nxt;
  logic                md_done;
  logic [MD_P_W-1:0]   md_result;

  // Output register
  logic        out_valid_r, out_valid_nxt;
  logic [24:0] out_heading_r, out_heading_nxt;
  logic        out_fwd_r, out_fwd_nxt;
  logic        out_cal_r, out_cal_nxt;

  // Datapath
  logic                          accept;
  logic signed [SAMPLE_BITS-1:0] samp;
  logic [31:0]                   samp_time;
  logic signed [CA_W-1:0]        acc_sum;
  logic [CA_W-1:0]               acc_mag;
  logic signed [CR_W-1:0]        corr;
  logic [RS_W-1:0]               run_mag;
  logic [31:0]                   dt_now;
  logic [SAMPLE_BITS-1:0]        q_low;
  logic [MD_P_W-MD_A_W-1:0]      prod_hi;
  logic [25:0]                   inc_ext;
  logic signed [26:0]            hd_sum;
  logic signed [26:0]            hd_wrap;
  logic [24:0]                   tol_lo;
  logic [24:0]                   tol_hi;
  logic                          facing;

  assign accept    = in_tvalid && in_tready;
  assign samp      = in_tdata[SAMPLE_BITS-1:0];
  assign samp_time = in_tdata[SAMPLE_BITS+31:SAMPLE_BITS];

  ghi_muldiv u_muldiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (md_ctl_r),
    .opa     (md_a_r),
    .opb     (md_b_r),
    .rem0    (md_rem_r),
    .divisor (md_dvs_r),
    .done    (md_done),
    .result  (md_result)
  );

  always_comb begin
    acc_sum = calib_acc_r + CA_W'(samp);
    acc_mag = acc_sum[CA_W-1] ? CA_W'(-acc_sum) : CA_W'(acc_sum);
    corr    = CR_W'(samp) - CR_W'(bias_r);
    run_mag = run_sum_r[RS_W-1] ? RS_W'(-run_sum_r) : RS_W'(run_sum_r);
    dt_now  = samp_time - last_time_r;
    q_low   = md_result[SAMPLE_BITS-1:0];
    prod_hi = md_result[MD_P_W-1:MD_A_W];

    // Heading step: signed increment, then wrap once into 0..360
    inc_ext = {1'b0, inc_r};
    hd_sum  = $signed({2'b00, heading_r})
              + (neg_r ? -$signed({1'b0, inc_ext}) : $signed({1'b0, inc_ext}));
    if (hd_sum > $signed({2'b00, DEG360_Q})) begin
      hd_wrap = hd_sum - $signed({2'b00, DEG360_Q});
    end else if (hd_sum < 0) begin
      hd_wrap = hd_sum + $signed({2'b00, DEG360_Q});
    end else begin
      hd_wrap = hd_sum;
    end

    // Facing forward: within tolerance either side of zero
    tol_lo = {1'b0, tol_r, 16'h0000};
    tol_hi = DEG360_Q - tol_lo;
    facing = (heading_r > tol_hi) || (heading_r < tol_lo);
  end

  always_comb begin
    calib_cfg_nxt  = calib_cfg_r;
    interval_nxt   = interval_r;
    gain_nxt       = gain_r;
    tol_nxt        = tol_r;
    state_nxt      = state_r;
    calib_left_nxt = calib_left_r;
    calib_acc_nxt  = calib_acc_r;
    bias_nxt       = bias_r;
    run_sum_nxt    = run_sum_r;
    run_count_nxt  = run_count_r;
    last_time_nxt  = last_time_r;
    heading_nxt    = heading_r;
    neg_nxt        = neg_r;
    dt_nxt         = dt_r;
    n_nxt          = n_r;
    inc_nxt        = inc_r;
    md_ctl_nxt     = '{start: 1'b0, op: md_ctl_r.op};
    md_a_nxt       = md_a_r;
    md_b_nxt       = md_b_r;
    md_rem_nxt     = md_rem_r;
    md_dvs_nxt     = md_dvs_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_heading_nxt = out_heading_r;
    out_fwd_nxt    = out_fwd_r;
    out_cal_nxt    = out_cal_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_DONE;
          if (calib_left_r != 11'd0) begin
            // Calibration: accumulate raw samples
            calib_acc_nxt  = acc_sum;
            calib_left_nxt = calib_left_r - 11'd1;
            if (calib_left_r == 11'd1) begin
              last_time_nxt = samp_time;
              run_sum_nxt   = '0;
              run_count_nxt = '0;
              neg_nxt       = acc_sum[CA_W-1];
              md_ctl_nxt    = '{start: 1'b1, op: OP_DIV};
              md_a_nxt      = MD_A_W'(acc_mag);
              md_rem_nxt    = '0;
              md_dvs_nxt    = MD_D_W'(eff_calib(calib_cfg_r));
              state_nxt     = S_CDIV;
            end
          end else if (dt_now > 32'(interval_r)) begin
            // Interval passed: drop this sample, restart the run
            last_time_nxt = samp_time;
            run_sum_nxt   = '0;
            run_count_nxt = '0;
            if (run_count_r != 16'd0) begin
              neg_nxt    = run_sum_r[RS_W-1];
              dt_nxt     = dt_now;
              n_nxt      = run_count_r;
              md_ctl_nxt = '{start: 1'b1, op: OP_MUL};
              md_a_nxt   = MD_A_W'(run_mag);
              md_b_nxt   = gain_r;
              state_nxt  = S_MUL1;
            end
          end else if (run_count_r < 16'(MAX_RUN_COUNT)) begin
            run_sum_nxt   = run_sum_r + RS_W'(corr);
            run_count_nxt = run_count_r + 16'd1;
          end
        end
      end
      S_CDIV: begin
        if (md_done) begin
          bias_nxt  = neg_r ? SAMPLE_BITS'(-q_low) : SAMPLE_BITS'(q_low);
          state_nxt = S_DONE;
        end
      end
      S_MUL1: begin
        if (md_done) begin
          if (prod_hi >= 32'(n_r)) begin
            // Quotient too large for any dt: skip the divide
            md_ctl_nxt = '{start: 1'b1, op: OP_MUL};
            md_a_nxt   = Q_SAT;
            md_b_nxt   = dt_r;
            state_nxt  = S_MUL2;
          end else begin
            md_ctl_nxt = '{start: 1'b1, op: OP_DIV};
            md_a_nxt   = md_result[MD_A_W-1:0];
            md_rem_nxt = prod_hi[MD_D_W-1:0];
            md_dvs_nxt = n_r;
            state_nxt  = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (md_done) begin
          md_ctl_nxt = '{start: 1'b1, op: OP_MUL};
          md_a_nxt   = md_result[MD_A_W-1:0];
          md_b_nxt   = dt_r;
          state_nxt  = S_MUL2;
        end
      end
      S_MUL2: begin
        if (md_done) begin
          // Saturate the increment at 359 degrees
          if (md_result > MD_P_W'(INC_TOP)) inc_nxt = INC_LIMIT_Q;
          else inc_nxt = md_result[40:16];
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        heading_nxt = hd_wrap[24:0];
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        // Hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt   = 1'b1;
          out_heading_nxt = heading_r;
          out_fwd_nxt     = facing;
          out_cal_nxt     = (calib_left_r != 11'd0);
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_wen) begin
      case (cfg_index)
        REG_CALIB_READINGS: begin
          calib_cfg_nxt  = cfg_wdata[10:0];
          calib_left_nxt = eff_calib(cfg_wdata[10:0]);
          calib_acc_nxt  = '0;
          run_sum_nxt    = '0;
          run_count_nxt  = '0;
        end
        REG_INTERVAL_MS:   interval_nxt = cfg_wdata[15:0];
        REG_GAIN:          gain_nxt     = cfg_wdata;
        REG_TOLERANCE_DEG: tol_nxt      = cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calib_cfg_r  <= CALIB_RESET;
      interval_r   <= INTERVAL_RESET;
      gain_r       <= GAIN_RESET;
      tol_r        <= TOL_RESET;
      state_r      <= S_IDLE;
      calib_left_r <= eff_calib(CALIB_RESET);
      calib_acc_r  <= '0;
      bias_r       <= '0;
      run_sum_r    <= '0;
      run_count_r  <= '0;
      last_time_r  <= '0;
      heading_r    <= '0;
      md_ctl_r     <= '{start: 1'b0, op: OP_MUL};
      out_valid_r  <= 1'b0;
    end else begin
      calib_cfg_r  <= calib_cfg_nxt;
      interval_r   <= interval_nxt;
      gain_r       <= gain_nxt;
      tol_r        <= tol_nxt;
      state_r      <= state_nxt;
      calib_left_r <= calib_left_nxt;
      calib_acc_r  <= calib_acc_nxt;
      bias_r       <= bias_nxt;
      run_sum_r    <= run_sum_nxt;
      run_count_r  <= run_count_nxt;
      last_time_r  <= last_time_nxt;
      heading_r    <= heading_nxt;
      md_ctl_r     <= md_ctl_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    neg_r         <= neg_nxt;
    dt_r          <= dt_nxt;
    n_r           <= n_nxt;
    inc_r         <= inc_nxt;
    md_a_r        <= md_a_nxt;
    md_b_r        <= md_b_nxt;
    md_rem_r      <= md_rem_nxt;
    md_dvs_r      <= md_dvs_nxt;
    out_heading_r <= out_heading_nxt;
    out_fwd_r     <= out_fwd_nxt;
    out_cal_r     <= out_cal_nxt;
  end

  // Accept only between items; the output register decouples the result side
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_heading_r};
  assign out_tuser  = {out_cal_r, out_fwd_r};

endmodule

### design/ghi_checker.sv
// Port-level checks for the gyro heading integrator, bound to the top level.
// Depends on ghi_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ghi_checker import ghi_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);

  `GHI_ASSERT_ALWAYS(a_reset_clears_out, clk, !rst_n |=> !out_tvalid, "result valid after reset")

  `GHI_ASSERT(a_out_hold, clk, rst_n,
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser),
    "stalled result changed")

  `GHI_ASSERT(a_heading_range, clk, rst_n, out_tvalid |-> out_tdata[24:0] <= DEG360_Q,
    "heading above 360 degrees")

  `GHI_ASSERT(a_one_at_a_time, clk, rst_n, in_tvalid && in_tready |=> !in_tready,
    "ready straight after a transaction")

endmodule

bind gyro_heading_integrator ghi_checker u_ghi_checker (.*);
